>>> rtl/core/skvlt_pkg.sv
// Shared types and codes for the sorted key/value leaf table.
// Used by skvlt_ctrl, skvlt_dp and sorted_key_value_leaf_table.
package skvlt_pkg;

    localparam int KEY_SLOTS_DEF    = 32;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int KIND_W    = 2;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int OCC_W     = 6;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;

    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

>>> rtl/core/sorted_key_value_leaf_table.sv
// Top level of the sorted key/value leaf table: controller plus datapath.
// Depends on skvlt_pkg, skvlt_ctrl and skvlt_dp.
//
// One leaf of an index: up to KEY_SLOTS signed keys kept in ascending order,
// each with a payload. The s_axis channel takes one operation per item: tuser
// selects search, insert or remove, tdata carries key and payload. The m_axis
// channel returns exactly one result item per operation: status, slot,
// payload read on a search hit, and the occupancy after the operation.
// An item is accepted in the idle cycle, which also compares all held slots
// against the incoming key in parallel and registers the outcome. The execute
// state then shifts, on an insert or remove, every slot at or above the
// insertion point by one in a single update, loads the result register and
// raises m_axis_tvalid. No new item is accepted until the previous one has
// left the execute state, because of the compare-then-shift pair on the slot array.
// A new item is accepted while a previous result still waits; the execute
// step holds until the result register is free, so a stalled receiver backs
// up to s_axis_tready after one item. Reset empties the table; slot contents
// are not cleared and are never read until written.
module sorted_key_value_leaf_table
    import skvlt_pkg::*;
#(
    parameter int KEY_SLOTS    = KEY_SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[31:0], payload[95:32]
    input  logic [KIND_W-1:0]     s_axis_tuser,   // kind[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[1:0], slot[7:2],
                                                  // read_payload[71:8],
                                                  // occupancy[77:72], zero[79:78]
);

    t_dp_cmd               cmd;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [PAY_W-1:0]      read_payload;
    logic [OCC_W-1:0]      occupancy;

    skvlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    skvlt_dp #(
        .KEY_SLOTS    (KEY_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (s_axis_tuser),
        .i_key          (s_axis_tdata[KEY_W-1:0]),
        .i_payload      (s_axis_tdata[KEY_W+PAY_W-1:KEY_W]),
        .o_status       (status),
        .o_slot         (slot),
        .o_read_payload (read_payload),
        .o_occupancy    (occupancy)
    );

    assign m_axis_tdata = {2'b00, occupancy, read_payload, slot, status};

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted in back-to-back cycles");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == STAT_FULL)) |-> (occupancy == OCC_W'(KEY_SLOTS)))
        else $error("table-full status with occupancy below capacity");

    a_payload_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status != STAT_DONE)) |-> (read_payload == '0))
        else $error("nonzero payload on a failed operation");

    a_no_cmd_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

>>> rtl/core/skvlt_ctrl.sv
// Controller for the leaf table: sequences capture/compare and execute.
// Depends on skvlt_pkg.
module skvlt_ctrl
    import skvlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/skvlt_dp.sv
// Datapath for the leaf table: slot array, parallel compare, shift update, result register.
// Depends on skvlt_pkg; driven by skvlt_ctrl commands.
module skvlt_dp
    import skvlt_pkg::*;
#(
    parameter int KEY_SLOTS    = KEY_SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [KEY_W-1:0]    i_key,
    input  logic [PAY_W-1:0]           i_payload,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [PAY_W-1:0]           o_read_payload,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int CW = $clog2(KEY_SLOTS + 1);

    logic signed [KEY_W-1:0]    r_keys [KEY_SLOTS];
    logic [PAYLOAD_BITS-1:0]    r_pays [KEY_SLOTS];
    logic signed [KEY_W-1:0]    n_keys [KEY_SLOTS];
    logic [PAYLOAD_BITS-1:0]    n_pays [KEY_SLOTS];
    logic [CW-1:0]              r_count, n_count;

    logic [KEY_SLOTS:0]         r_lt, n_lt;
    logic [KEY_SLOTS-1:0]       r_eq, n_eq;
    logic [KIND_W-1:0]          r_kind;
    logic signed [KEY_W-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0]    r_pay;

    logic [STATUS_W-1:0]        r_status, n_status;
    logic [SLOT_W-1:0]          r_slot;
    logic [PAY_W-1:0]           r_rdpay;
    logic [OCC_W-1:0]           r_occ;

    logic [KEY_SLOTS:0]         first;
    logic [CW-1:0]              pos;
    logic                       hit;
    logic [PAYLOAD_BITS-1:0]    rdpay;
    logic                       do_ins;
    logic                       do_rem;

    // compare every held slot against the incoming key
    always_comb begin
        n_lt = '0;
        n_eq = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (CW'(i) < r_count) begin
                n_lt[i] = r_keys[i] < i_key;
                n_eq[i] = r_keys[i] == i_key;
            end
        end
    end

    // locate the insertion point from the thermometer of smaller keys
    always_comb begin
        pos   = '0;
        rdpay = '0;
        for (int i = 0; i <= KEY_SLOTS; i++) begin
            first[i] = ((i == 0) ? 1'b1 : r_lt[(i == 0) ? 0 : i - 1]) && !r_lt[i];
            if (first[i]) begin
                pos = pos | CW'(i);
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_eq[i]) begin
                rdpay = rdpay | r_pays[i];
            end
        end
        hit = |r_eq;
    end

    always_comb begin
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        n_count  = r_count;
        n_status = STAT_DONE;
        case (r_kind)
            KIND_INSERT: begin
                if (hit) begin
                    n_status = STAT_DUPLICATE;
                end else if (r_count == CW'(KEY_SLOTS)) begin
                    n_status = STAT_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_REMOVE: begin
                if (!hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                if (!hit) begin
                    n_status = STAT_NOT_FOUND;
                end
            end
        endcase
    end

    // on an insert or remove, shift every slot at or above the insertion point by one
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            n_keys[i] = r_keys[i];
            n_pays[i] = r_pays[i];
            if (do_ins && !r_lt[i]) begin
                if (first[i]) begin
                    n_keys[i] = r_key;
                    n_pays[i] = r_pay;
                end else if (i > 0) begin
                    n_keys[i] = r_keys[(i == 0) ? 0 : i - 1];
                    n_pays[i] = r_pays[(i == 0) ? 0 : i - 1];
                end
            end else if (do_rem && !r_lt[i] && (i < KEY_SLOTS - 1)) begin
                n_keys[i] = r_keys[(i < KEY_SLOTS - 1) ? i + 1 : i];
                n_pays[i] = r_pays[(i < KEY_SLOTS - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_keys <= n_keys;
            r_pays <= n_pays;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lt   <= n_lt;
            r_eq   <= n_eq;
            r_kind <= i_kind;
            r_key  <= i_key;
            r_pay  <= i_payload[PAYLOAD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_slot   <= SLOT_W'(pos);
            r_occ    <= OCC_W'(n_count);
            if ((r_kind != KIND_INSERT) && (r_kind != KIND_REMOVE) && hit) begin
                r_rdpay <= PAY_W'(rdpay);
            end else begin
                r_rdpay <= '0;
            end
        end
    end

    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_read_payload = r_rdpay;
    assign o_occupancy    = r_occ;

endmodule

>>> test/leaf_table_checker.sv
// Checker for sorted_key_value_leaf_table: watches the operation and result
// channels, keeps its own copy of the sorted table and compares every result.
// Depends on skvlt_pkg for field widths and the operation and status codes.
module leaf_table_checker
    import skvlt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    input  logic                  i_op_ready,
    input  logic [IN_DATA_W-1:0]  i_op_data,    // key[31:0], payload[95:32]
    input  logic [KIND_W-1:0]     i_op_kind,    // kind[1:0]
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_DATA_W-1:0] i_res_data,   // status[1:0], slot[7:2],
                                                // read_payload[71:8],
                                                // occupancy[77:72], zero[79:78]
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_full_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = KEY_SLOTS_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]          pad;
        logic [OCC_W-1:0]    occupancy;
        logic [PAY_W-1:0]    read_payload;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } t_table_reply;

    logic signed [KEY_W-1:0] key_row    [SLOTS];
    logic [PAY_W-1:0]        record_row [SLOTS];
    int                      held       = 0;
    t_table_reply            replies_due [$];
    int                      fails      = 0;
    int                      checked    = 0;
    int                      full_seen  = 0;

    function automatic t_table_reply apply_op(input logic [KIND_W-1:0] kind,
                                              input logic signed [KEY_W-1:0] key,
                                              input logic [PAY_W-1:0] pay);
        t_table_reply r;
        int           pos;
        int           i;
        bit           hit;
        r   = '0;
        pos = 0;
        for (i = 0; i < held; i++) begin
            if (key_row[i] < key) pos++;
        end
        hit = (pos < held) && (key_row[pos] == key);
        r.status = STAT_DONE;
        case (kind)
            KIND_INSERT: begin
                if (hit) begin
                    r.status = STAT_DUPLICATE;
                end else if (held >= SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = held; i > pos; i--) begin
                        key_row[i]    = key_row[i-1];
                        record_row[i] = record_row[i-1];
                    end
                    key_row[pos]    = key;
                    record_row[pos] = pay;
                    held++;
                end
            end
            KIND_REMOVE: begin
                if (!hit) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (i = pos; i + 1 < held; i++) begin
                        key_row[i]    = key_row[i+1];
                        record_row[i] = record_row[i+1];
                    end
                    held--;
                end
            end
            default: begin
                if (hit) r.read_payload = record_row[pos];
                else r.status = STAT_NOT_FOUND;
            end
        endcase
        r.slot      = pos[SLOT_W-1:0];
        r.occupancy = held[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_table_reply got;
        t_table_reply want;
        if (!i_rst_n) begin
            held = 0;
            replies_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = t_table_reply'(i_res_data);
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: result item %h with no operation outstanding",
                                 $realtime, i_res_data);
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.read_payload !== want.read_payload ||
                        got.occupancy !== want.occupancy || got.pad !== want.pad) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result %0d expected status %0d slot %0d payload %h occ %0d",
                                     $realtime, checked, want.status, want.slot,
                                     want.read_payload, want.occupancy);
                            $display("%0t: result %0d got      status %0d slot %0d payload %h occ %0d pad %b",
                                     $realtime, checked, got.status, got.slot,
                                     got.read_payload, got.occupancy, got.pad);
                        end
                    end
                end
            end
            if (i_op_valid && i_op_ready) begin
                want = apply_op(i_op_kind, i_op_data[KEY_W-1:0], i_op_data[KEY_W +: PAY_W]);
                if (want.status == STAT_FULL) full_seen++;
                replies_due.push_back(want);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= replies_due.size();
        o_checked       <= checked;
        o_full_refusals <= full_seen;
    end

endmodule

>>> test/tb_top.sv
// Top of the sorted_key_value_leaf_table testbench: clock, reset, operation
// stimulus, receiver stalls, watchdog and verdict.
// Depends on skvlt_pkg, the block itself and leaf_table_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import skvlt_pkg::*;

    localparam int                      CLK_PERIOD      = 12;
    localparam int                      RESET_CYCLES    = 7;
    localparam int                      WATCHDOG_LIMIT  = 4000;
    localparam int                      SETTLE_CYCLES   = 8;
    localparam int                      ITEMS_PER_PHASE = 445;
    localparam int                      POOL_DEPTH      = 48;
    localparam logic [KIND_W-1:0]       KIND_SPARE      = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN         = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX         = 32'sh7fff_ffff;
    localparam int                      MODE_FILL       = 0;
    localparam int                      MODE_DRAIN      = 1;
    localparam int                      MODE_MIX        = 2;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // key[31:0], payload[95:32]
    logic [KIND_W-1:0]     s_axis_tuser;    // kind[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // status[1:0], slot[7:2], read_payload[71:8],
                                            // occupancy[77:72], zero[79:78]

    int                      fail_count;
    int                      pending;
    int                      checked;
    int                      full_refusals;
    int                      tx_idle_pct;
    int                      rx_idle_pct;
    int                      quiet_cycles = 0;
    int                      sent_by_kind [4] = '{default: 0};
    logic signed [KEY_W-1:0] key_pool [$];

    sorted_key_value_leaf_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    leaf_table_checker u_table_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (s_axis_tvalid),
        .i_op_ready      (s_axis_tready),
        .i_op_data       (s_axis_tdata),
        .i_op_kind       (s_axis_tuser),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pay, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_by_kind[kind]++;
        key_pool.push_back(key);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(input int pool_pct);
        int roll;
        roll = $urandom_range(99);
        if (key_pool.size() > 0 && roll < pool_pct)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if (roll < pool_pct + 8) begin
            case ($urandom_range(3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_op(input int mode);
        int                roll;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:
                kind = roll < 75 ? KIND_INSERT : roll < 90 ? KIND_SEARCH :
                       roll < 98 ? KIND_REMOVE : KIND_SPARE;
            MODE_DRAIN:
                kind = roll < 70 ? KIND_REMOVE : roll < 90 ? KIND_SEARCH :
                       roll < 98 ? KIND_INSERT : KIND_SPARE;
            default:
                kind = roll < 35 ? KIND_INSERT : roll < 70 ? KIND_SEARCH :
                       roll < 97 ? KIND_REMOVE : KIND_SPARE;
        endcase
        send_op(kind, pick_key(kind == KIND_INSERT ? 20 : 75), {$urandom, $urandom});
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int done_items;
        int mode;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done_items  = 0;
        mode        = MODE_FILL;
        len         = 80;
        while (done_items < ITEMS_PER_PHASE) begin
            repeat (len) begin
                random_op(mode);
                done_items++;
            end
            mode = $urandom_range(MODE_MIX);
            len  = $urandom_range(20, 60);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_SEARCH;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 17;
        rx_idle_pct   = 58;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(KIND_SEARCH, 32'sd0, 64'h0);
        send_op(KIND_REMOVE, 32'sd5, 64'h0);
        send_op(KIND_SPARE,  32'sd0, 64'hffff_ffff_ffff_ffff);
        send_op(KIND_INSERT, KEY_MIN, 64'hffff_ffff_ffff_ffff);
        send_op(KIND_INSERT, KEY_MAX, 64'h0);
        send_op(KIND_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef);
        send_op(KIND_INSERT, -32'sd1, 64'ha5a5_a5a5_a5a5_a5a5);
        send_op(KIND_INSERT, 32'sd1, 64'h5a5a_5a5a_5a5a_5a5a);
        send_op(KIND_INSERT, KEY_MIN, 64'hdead_beef_0000_0001);
        send_op(KIND_INSERT, 32'sd0, 64'h1);
        send_op(KIND_SEARCH, KEY_MIN, 64'h0);
        send_op(KIND_SEARCH, KEY_MAX, 64'hffff_ffff_ffff_ffff);
        send_op(KIND_SEARCH, 32'sd2, 64'h0);
        send_op(KIND_SPARE,  -32'sd1, 64'h0);
        send_op(KIND_REMOVE, 32'sd0, 64'h0);
        send_op(KIND_REMOVE, 32'sd0, 64'h0);
        send_op(KIND_SEARCH, 32'sd1, 64'h0);
        send_op(KIND_REMOVE, KEY_MAX, 64'h0);
        send_op(KIND_REMOVE, KEY_MIN, 64'h0);
        send_op(KIND_SEARCH, -32'sd1, 64'h0);
        send_op(KIND_INSERT, 32'sh4000_0000, {$urandom, $urandom});
        send_op(KIND_REMOVE, 32'sd1, 64'h0);
        send_op(KIND_REMOVE, -32'sd1, 64'h0);
        send_op(KIND_REMOVE, 32'sh4000_0000, 64'h0);

        run_phase(17, 58);
        run_phase(58, 17);
        run_phase(0, 0);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d operations: %0d searches, %0d inserts, %0d removes, %0d spare kind",
                 sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
                 sent_by_kind[KIND_SEARCH], sent_by_kind[KIND_INSERT],
                 sent_by_kind[KIND_REMOVE], sent_by_kind[KIND_SPARE]);
        $display("Checked %0d results, %0d of them inserts refused by a full table",
                 checked, full_refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
